// ----- hdl/nlst_pkg.sv -----
package nlst_pkg;

  localparam int NODE_COUNT = 256;
  localparam int NODE_AW    = $clog2(NODE_COUNT);
  localparam int NODE_W     = 8;
  localparam int COORD_W    = 32;
  localparam int SPAN_W     = 32;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FLAT = 1'b1;

  localparam logic [SPAN_W-1:0] SCALE_UNSET = '1;

  typedef enum logic [1:0] {
    REQ_APPLY = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    CMD_APPLY,
    CMD_FLAT,
    CMD_READ,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [NODE_W-1:0]   node_c;
    logic [SPAN_W-1:0]   span_x;
    logic [SPAN_W-1:0]   span_y;
  } cmd_t;

  typedef struct packed {
    logic                valid;
    logic                status;
    logic [SPAN_W-1:0]   scale_x;
    logic [SPAN_W-1:0]   scale_y;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_NODE_A,
    BK_NODE_B,
    BK_NODE_C,
    BK_READ
  } back_state_t;

  function automatic logic [NODE_AW-1:0] node_addr(logic [NODE_W-1:0] n);
    return NODE_AW'(n);
  endfunction

  function automatic logic node_in_range(logic [NODE_W-1:0] n);
    return (32'(n) < 32'(NODE_COUNT));
  endfunction

endpackage

// ----- hdl/node_length_scale_tracker.sv -----
// The result strobe is registered: a request is written into the command queue, the back end
// takes it from the queue head, and its result is registered when the back end retires it.
// A triangle first walks states NODE_A, NODE_B and NODE_C, the read-modify-write of its three
// nodes; a read walks READ; one clear or flat triangle per cycle while no earlier command is in work.
// A 2-entry command queue lets start be taken while the back end works; busy marks it full.
// Reset (rst_n low, synchronous) empties the queue and marks every node unset.
module node_length_scale_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_req_type,
  input  logic [nlst_pkg::NODE_W-1:0]         in_node_a,
  input  logic [nlst_pkg::NODE_W-1:0]         in_node_b,
  input  logic [nlst_pkg::NODE_W-1:0]         in_node_c,
  input  logic signed [nlst_pkg::COORD_W-1:0] in_x_a,
  input  logic signed [nlst_pkg::COORD_W-1:0] in_y_a,
  input  logic signed [nlst_pkg::COORD_W-1:0] in_x_b,
  input  logic signed [nlst_pkg::COORD_W-1:0] in_y_b,
  input  logic signed [nlst_pkg::COORD_W-1:0] in_x_c,
  input  logic signed [nlst_pkg::COORD_W-1:0] in_y_c,
  output logic                                out_valid,
  output logic                                out_status,
  output logic [nlst_pkg::SPAN_W-1:0]         out_scale_x,
  output logic [nlst_pkg::SPAN_W-1:0]         out_scale_y
);

  nlst_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_pop;

  nlst_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req_type (in_req_type),
    .in_node_a   (in_node_a),
    .in_node_b   (in_node_b),
    .in_node_c   (in_node_c),
    .in_x_a      (in_x_a),
    .in_y_a      (in_y_a),
    .in_x_b      (in_x_b),
    .in_y_b      (in_y_b),
    .in_x_c      (in_x_c),
    .in_y_c      (in_y_c),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop)
  );

  nlst_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_scale_x (out_scale_x),
    .out_scale_y (out_scale_y)
  );

endmodule

// ----- hdl/nlst_front.sv -----
module nlst_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_req_type,
  input  logic [nlst_pkg::NODE_W-1:0]       in_node_a,
  input  logic [nlst_pkg::NODE_W-1:0]       in_node_b,
  input  logic [nlst_pkg::NODE_W-1:0]       in_node_c,
  input  logic signed [nlst_pkg::COORD_W-1:0] in_x_a,
  input  logic signed [nlst_pkg::COORD_W-1:0] in_y_a,
  input  logic signed [nlst_pkg::COORD_W-1:0] in_x_b,
  input  logic signed [nlst_pkg::COORD_W-1:0] in_y_b,
  input  logic signed [nlst_pkg::COORD_W-1:0] in_x_c,
  input  logic signed [nlst_pkg::COORD_W-1:0] in_y_c,
  output nlst_pkg::cmd_t                    cmd,
  output logic                              cmd_valid,
  input  logic                              cmd_pop
);

  function automatic logic [nlst_pkg::SPAN_W-1:0] span3(
    logic signed [nlst_pkg::COORD_W-1:0] a,
    logic signed [nlst_pkg::COORD_W-1:0] b,
    logic signed [nlst_pkg::COORD_W-1:0] c
  );
    logic signed [nlst_pkg::COORD_W-1:0] lo;
    logic signed [nlst_pkg::COORD_W-1:0] hi;
    lo = a;
    hi = a;
    if (b < lo) lo = b;
    if (b > hi) hi = b;
    if (c < lo) lo = c;
    if (c > hi) hi = c;
    // max minus min of 32-bit values always fits 32 unsigned bits
    return nlst_pkg::SPAN_W'(hi - lo);
  endfunction

  nlst_pkg::cmd_t                 q_r [nlst_pkg::QDEPTH];
  logic [nlst_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [nlst_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [nlst_pkg::QCNT_W-1:0]    count_r, count_nxt;
  nlst_pkg::cmd_t                 new_cmd;
  logic                           push;

  assign busy      = (count_r == nlst_pkg::QCNT_W'(nlst_pkg::QDEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  // classify the request and form the spans on the way in
  always_comb begin
    new_cmd        = '0;
    new_cmd.node_a = in_node_a;
    new_cmd.node_b = in_node_b;
    new_cmd.node_c = in_node_c;
    new_cmd.span_x = span3(in_x_a, in_x_b, in_x_c);
    new_cmd.span_y = span3(in_y_a, in_y_b, in_y_c);
    case (in_req_type)
      nlst_pkg::REQ_APPLY: begin
        if (new_cmd.span_x == '0 || new_cmd.span_y == '0) begin
          new_cmd.kind = nlst_pkg::CMD_FLAT;
        end else begin
          new_cmd.kind = nlst_pkg::CMD_APPLY;
        end
      end
      nlst_pkg::REQ_READ:  new_cmd.kind = nlst_pkg::CMD_READ;
      nlst_pkg::REQ_CLEAR: new_cmd.kind = nlst_pkg::CMD_CLEAR;
      default:             new_cmd.kind = nlst_pkg::CMD_NOP;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == nlst_pkg::QPTR_W'(nlst_pkg::QDEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (cmd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == nlst_pkg::QPTR_W'(nlst_pkg::QDEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !cmd_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && cmd_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ----- hdl/nlst_back.sv -----
module nlst_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nlst_pkg::cmd_t                cmd,
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  output logic                          out_valid,
  output logic                          out_status,
  output logic [nlst_pkg::SPAN_W-1:0]   out_scale_x,
  output logic [nlst_pkg::SPAN_W-1:0]   out_scale_y
);

  localparam int ENTRY_W = 2 * nlst_pkg::SPAN_W;

  nlst_pkg::back_state_t            state_r, state_nxt;
  logic [ENTRY_W-1:0]               span_mem [nlst_pkg::NODE_COUNT];
  logic [nlst_pkg::NODE_COUNT-1:0]  valid_r;
  logic [ENTRY_W-1:0]               rd_data_r;
  logic                             rd_en;
  logic [nlst_pkg::NODE_AW-1:0]     rd_addr;
  logic                             wr_en;
  logic [ENTRY_W-1:0]               wr_data;
  logic                             wr_last_r;
  logic [nlst_pkg::NODE_AW-1:0]     wr_addr_r;
  logic [ENTRY_W-1:0]               wr_data_r;
  logic                             clr_all;
  logic [nlst_pkg::NODE_W-1:0]      proc_node;
  logic [nlst_pkg::NODE_AW-1:0]     proc_addr;
  logic                             proc_ok;
  logic                             proc_valid;
  logic [ENTRY_W-1:0]               cur;
  logic [nlst_pkg::SPAN_W-1:0]      cur_x, cur_y, new_x, new_y;
  nlst_pkg::result_t                res_nxt;
  logic                             out_valid_r;
  logic                             out_status_r;
  logic [nlst_pkg::SPAN_W-1:0]      out_scale_x_r, out_scale_y_r;

  // node whose entry comes back from the store this cycle
  always_comb begin
    case (state_r)
      nlst_pkg::BK_NODE_B: proc_node = cmd.node_b;
      nlst_pkg::BK_NODE_C: proc_node = cmd.node_c;
      default:             proc_node = cmd.node_a;
    endcase
  end

  assign proc_addr  = nlst_pkg::node_addr(proc_node);
  assign proc_ok    = nlst_pkg::node_in_range(proc_node);
  assign proc_valid = valid_r[proc_addr];
  // forward the write of the previous cycle, else a repeated node would read stale data
  assign cur   = (wr_last_r && wr_addr_r == proc_addr) ? wr_data_r : rd_data_r;
  assign cur_x = cur[ENTRY_W-1:nlst_pkg::SPAN_W];
  assign cur_y = cur[nlst_pkg::SPAN_W-1:0];
  assign new_x = (proc_valid && cur_x <= cmd.span_x) ? cur_x : cmd.span_x;
  assign new_y = (proc_valid && cur_y <= cmd.span_y) ? cur_y : cmd.span_y;
  assign wr_data = {new_x, new_y};

  always_comb begin
    state_nxt = state_r;
    cmd_pop   = 1'b0;
    res_nxt   = '0;
    rd_en     = 1'b0;
    rd_addr   = nlst_pkg::node_addr(cmd.node_a);
    wr_en     = 1'b0;
    clr_all   = 1'b0;
    case (state_r)
      nlst_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            nlst_pkg::CMD_APPLY: begin
              rd_en     = 1'b1;
              state_nxt = nlst_pkg::BK_NODE_A;
            end
            nlst_pkg::CMD_READ: begin
              rd_en     = 1'b1;
              state_nxt = nlst_pkg::BK_READ;
            end
            nlst_pkg::CMD_CLEAR: begin
              clr_all       = 1'b1;
              res_nxt.valid = 1'b1;
              cmd_pop       = 1'b1;
            end
            nlst_pkg::CMD_FLAT: begin
              res_nxt.valid  = 1'b1;
              res_nxt.status = nlst_pkg::STATUS_FLAT;
              cmd_pop        = 1'b1;
            end
            default: begin
              res_nxt.valid = 1'b1;
              cmd_pop       = 1'b1;
            end
          endcase
        end
      end
      nlst_pkg::BK_NODE_A: begin
        wr_en     = proc_ok;
        rd_en     = 1'b1;
        rd_addr   = nlst_pkg::node_addr(cmd.node_b);
        state_nxt = nlst_pkg::BK_NODE_B;
      end
      nlst_pkg::BK_NODE_B: begin
        wr_en     = proc_ok;
        rd_en     = 1'b1;
        rd_addr   = nlst_pkg::node_addr(cmd.node_c);
        state_nxt = nlst_pkg::BK_NODE_C;
      end
      nlst_pkg::BK_NODE_C: begin
        wr_en         = proc_ok;
        res_nxt.valid = 1'b1;
        cmd_pop       = 1'b1;
        state_nxt     = nlst_pkg::BK_IDLE;
      end
      nlst_pkg::BK_READ: begin
        res_nxt.valid = 1'b1;
        if (proc_ok && proc_valid) begin
          res_nxt.scale_x = rd_data_r[ENTRY_W-1:nlst_pkg::SPAN_W];
          res_nxt.scale_y = rd_data_r[nlst_pkg::SPAN_W-1:0];
        end else begin
          res_nxt.scale_x = nlst_pkg::SCALE_UNSET;
          res_nxt.scale_y = nlst_pkg::SCALE_UNSET;
        end
        cmd_pop   = 1'b1;
        state_nxt = nlst_pkg::BK_IDLE;
      end
      default: state_nxt = nlst_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nlst_pkg::BK_IDLE;
      wr_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_last_r   <= wr_en;
      out_valid_r <= res_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (clr_all) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[proc_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      span_mem[proc_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= span_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wr_addr_r <= proc_addr;
      wr_data_r <= wr_data;
    end
    out_status_r  <= res_nxt.status;
    out_scale_x_r <= res_nxt.scale_x;
    out_scale_y_r <= res_nxt.scale_y;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_scale_x = out_scale_x_r;
  assign out_scale_y = out_scale_y_r;

  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != nlst_pkg::BK_IDLE) |-> cmd_valid)
    else $error("command left the queue while still in work");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop == res_nxt.valid)
    else $error("command retired without exactly one result");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == nlst_pkg::BK_NODE_A || state_r == nlst_pkg::BK_NODE_B ||
               state_r == nlst_pkg::BK_NODE_C))
    else $error("table write outside a node update");

  a_node_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nlst_pkg::BK_NODE_C) |-> ($past(state_r) == nlst_pkg::BK_NODE_B))
    else $error("third node processed out of order");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd_pop))
    else $error("result strobe without a retired command");

endmodule

// ----- tb/node_length_scale_tracker_test.sv -----
module node_length_scale_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]                   req;
    logic [nlst_pkg::NODE_W-1:0]  node_a;
    logic [nlst_pkg::NODE_W-1:0]  node_b;
    logic [nlst_pkg::NODE_W-1:0]  node_c;
    logic [nlst_pkg::COORD_W-1:0] x_a;
    logic [nlst_pkg::COORD_W-1:0] y_a;
    logic [nlst_pkg::COORD_W-1:0] x_b;
    logic [nlst_pkg::COORD_W-1:0] y_b;
    logic [nlst_pkg::COORD_W-1:0] x_c;
    logic [nlst_pkg::COORD_W-1:0] y_c;
  } request_t;

  typedef struct packed {
    logic                        status;
    logic [nlst_pkg::SPAN_W-1:0] scale_x;
    logic [nlst_pkg::SPAN_W-1:0] scale_y;
  } scales_t;

  // Holds its own copy of the node table and the results still owed by the block.
  class node_scale_board;
    logic [nlst_pkg::SPAN_W-1:0] min_x[nlst_pkg::NODE_COUNT];
    logic [nlst_pkg::SPAN_W-1:0] min_y[nlst_pkg::NODE_COUNT];
    logic                        node_set[nlst_pkg::NODE_COUNT];
    scales_t                     owed_scales[$];
    int unsigned                 mismatches;

    function new();
      foreach (node_set[i]) node_set[i] = 1'b0;
      mismatches = 0;
    endfunction

    function logic [nlst_pkg::SPAN_W-1:0] span3(logic [nlst_pkg::COORD_W-1:0] a,
                                                logic [nlst_pkg::COORD_W-1:0] b,
                                                logic [nlst_pkg::COORD_W-1:0] c);
      logic signed [nlst_pkg::COORD_W-1:0] lo;
      logic signed [nlst_pkg::COORD_W-1:0] hi;
      lo = a;
      hi = a;
      if ($signed(b) < lo) lo = b;
      if ($signed(b) > hi) hi = b;
      if ($signed(c) < lo) lo = c;
      if ($signed(c) > hi) hi = c;
      // the true difference always fits in 32 unsigned bits, so wrapping is exact
      return hi - lo;
    endfunction

    function void lower_node(logic [nlst_pkg::NODE_W-1:0] idx,
                             logic [nlst_pkg::SPAN_W-1:0] sx,
                             logic [nlst_pkg::SPAN_W-1:0] sy);
      if (idx >= nlst_pkg::NODE_COUNT) return;
      if (!node_set[idx]) begin
        min_x[idx] = sx;
        min_y[idx] = sy;
        node_set[idx] = 1'b1;
        return;
      end
      if (sx < min_x[idx]) min_x[idx] = sx;
      if (sy < min_y[idx]) min_y[idx] = sy;
    endfunction

    function void note_request(request_t r);
      scales_t                     e;
      logic [nlst_pkg::SPAN_W-1:0] sx;
      logic [nlst_pkg::SPAN_W-1:0] sy;
      e.status  = nlst_pkg::STATUS_DONE;
      e.scale_x = '0;
      e.scale_y = '0;
      case (r.req)
        nlst_pkg::REQ_APPLY: begin
          sx = span3(r.x_a, r.x_b, r.x_c);
          sy = span3(r.y_a, r.y_b, r.y_c);
          if (sx == '0 || sy == '0) begin
            e.status = nlst_pkg::STATUS_FLAT;
          end else begin
            lower_node(r.node_a, sx, sy);
            lower_node(r.node_b, sx, sy);
            lower_node(r.node_c, sx, sy);
          end
        end
        nlst_pkg::REQ_READ: begin
          if (r.node_a < nlst_pkg::NODE_COUNT && node_set[r.node_a]) begin
            e.scale_x = min_x[r.node_a];
            e.scale_y = min_y[r.node_a];
          end else begin
            e.scale_x = nlst_pkg::SCALE_UNSET;
            e.scale_y = nlst_pkg::SCALE_UNSET;
          end
        end
        nlst_pkg::REQ_CLEAR: begin
          foreach (node_set[i]) node_set[i] = 1'b0;
        end
        default: ;
      endcase
      owed_scales.push_back(e);
    endfunction

    function void check_result(scales_t got);
      scales_t e;
      if (owed_scales.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing outstanding: status %0b x %h y %h",
                   $realtime, got.status, got.scale_x, got.scale_y);
        return;
      end
      e = owed_scales.pop_front();
      if (got.status !== e.status || got.scale_x !== e.scale_x ||
          got.scale_y !== e.scale_y) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: status %0b/%0b x %h/%h y %h/%h (expected/actual)",
                   $realtime, e.status, got.status, e.scale_x, got.scale_x,
                   e.scale_y, got.scale_y);
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  request_t                    beat;
  logic                        out_valid;
  logic                        out_status;
  logic [nlst_pkg::SPAN_W-1:0] out_scale_x;
  logic [nlst_pkg::SPAN_W-1:0] out_scale_y;

  node_scale_board             board = new();
  bit                          idle_ok;
  logic [nlst_pkg::NODE_W-1:0] hot_base;

  node_length_scale_tracker DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req_type (beat.req),
    .in_node_a   (beat.node_a),
    .in_node_b   (beat.node_b),
    .in_node_c   (beat.node_c),
    .in_x_a      (beat.x_a),
    .in_y_a      (beat.y_a),
    .in_x_b      (beat.x_b),
    .in_y_b      (beat.y_b),
    .in_x_c      (beat.x_c),
    .in_y_c      (beat.y_c),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_scale_x (out_scale_x),
    .out_scale_y (out_scale_y)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) board.note_request(beat);
      if (out_valid === 1'b1) board.check_result({out_status, out_scale_x, out_scale_y});
    end
  end

  // Present one beat at the falling edge and hold it until the block takes it.
  task automatic send(request_t r);
    while (idle_ok && $urandom_range(99) < 19) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    beat  <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic request_t make_apply(logic [nlst_pkg::NODE_W-1:0] na,
                                          logic [nlst_pkg::NODE_W-1:0] nb,
                                          logic [nlst_pkg::NODE_W-1:0] nc,
                                          logic [nlst_pkg::COORD_W-1:0] xa,
                                          logic [nlst_pkg::COORD_W-1:0] ya,
                                          logic [nlst_pkg::COORD_W-1:0] xb,
                                          logic [nlst_pkg::COORD_W-1:0] yb,
                                          logic [nlst_pkg::COORD_W-1:0] xc,
                                          logic [nlst_pkg::COORD_W-1:0] yc);
    request_t r;
    r.req    = nlst_pkg::REQ_APPLY;
    r.node_a = na;
    r.node_b = nb;
    r.node_c = nc;
    r.x_a    = xa;
    r.y_a    = ya;
    r.x_b    = xb;
    r.y_b    = yb;
    r.x_c    = xc;
    r.y_c    = yc;
    return r;
  endfunction

  // Non-apply requests carry random junk in the unused fields.
  function automatic request_t make_other(logic [1:0] req, logic [nlst_pkg::NODE_W-1:0] na);
    request_t r;
    r = make_apply(nlst_pkg::NODE_W'($urandom), nlst_pkg::NODE_W'($urandom),
                   nlst_pkg::NODE_W'($urandom), $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
    r.req    = req;
    r.node_a = na;
    return r;
  endfunction

  function automatic logic [nlst_pkg::COORD_W-1:0] near(logic [nlst_pkg::COORD_W-1:0] base);
    logic [nlst_pkg::COORD_W-1:0] off;
    off = $urandom >> $urandom_range(31, 0);
    return $urandom_range(1) ? base + off : base - off;
  endfunction

  function automatic logic [nlst_pkg::NODE_W-1:0] pick_node();
    if ($urandom_range(99) < 75) return hot_base + nlst_pkg::NODE_W'($urandom_range(7));
    return nlst_pkg::NODE_W'($urandom_range(255));
  endfunction

  function automatic request_t random_triangle();
    request_t                     r;
    logic [nlst_pkg::COORD_W-1:0] bx;
    logic [nlst_pkg::COORD_W-1:0] by;
    int                           roll;
    bx = $urandom;
    by = $urandom;
    r = make_apply(pick_node(), pick_node(), pick_node(), near(bx), near(by), near(bx),
                   near(by), near(bx), near(by));
    roll = $urandom_range(99);
    if (roll < 5) begin
      r.x_b = r.x_a;
      r.x_c = r.x_a;
    end else if (roll < 10) begin
      r.y_b = r.y_a;
      r.y_c = r.y_a;
    end else if (roll < 25) begin
      r.node_b = r.node_a;
    end
    return r;
  endfunction

  initial begin
    int roll;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    beat     <= '0;
    idle_ok  = 1'b1;
    hot_base = nlst_pkg::NODE_W'($urandom);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // unset nodes at both ends of the table
    send(make_other(nlst_pkg::REQ_READ, 8'd0));
    send(make_other(nlst_pkg::REQ_READ, 8'd255));
    // widest possible spans
    send(make_apply(8'd0, 8'd1, 8'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h0, 32'h0));
    send(make_other(nlst_pkg::REQ_READ, 8'd0));
    // one node repeated three times, smallest spans
    send(make_apply(8'd0, 8'd0, 8'd0, 32'h0, 32'h5, 32'h1, 32'h5, 32'h0, 32'h6));
    send(make_other(nlst_pkg::REQ_READ, 8'd0));
    send(make_other(nlst_pkg::REQ_READ, 8'd1));
    // flat in x, flat in y, flat in both
    send(make_apply(8'd3, 8'd4, 8'd5, 32'h1234, 32'h0, 32'h1234, 32'h10, 32'h1234, 32'h20));
    send(make_apply(8'd3, 8'd4, 8'd5, 32'h0, 32'hFFFF_0000, 32'h10, 32'hFFFF_0000, 32'h20,
                    32'hFFFF_0000));
    send(make_apply(8'd3, 8'd4, 8'd5, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 32'hDEAD_BEEF,
                    32'hDEAD_BEEF, 32'hDEAD_BEEF, 32'hDEAD_BEEF));
    send(make_other(nlst_pkg::REQ_READ, 8'd3));
    // top indices, negative coordinates
    send(make_apply(8'd255, 8'd254, 8'd253, 32'hFFFF_0000, 32'hFFFE_8000, 32'hFFFF_8000,
                    32'hFFFF_FFFF, 32'hFFF0_0000, 32'hFFFF_0000));
    send(make_other(nlst_pkg::REQ_READ, 8'd255));
    // a wider triangle must not raise node 0
    send(make_apply(8'd0, 8'd255, 8'd7, 32'h0, 32'h0, 32'h100, 32'h100, 32'h50, 32'h50));
    send(make_other(nlst_pkg::REQ_READ, 8'd0));
    send(make_other(nlst_pkg::REQ_READ, 8'd255));
    send(make_other(REQ_UNUSED, 8'd0));
    send(make_other(nlst_pkg::REQ_READ, 8'd0));
    send(make_other(nlst_pkg::REQ_CLEAR, 8'd0));
    send(make_other(nlst_pkg::REQ_READ, 8'd0));
    send(make_other(nlst_pkg::REQ_READ, 8'd255));
    // after a clear, an apply writes spans outright even if larger
    send(make_apply(8'd0, 8'd9, 8'd10, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h0, 32'h0));
    send(make_other(nlst_pkg::REQ_READ, 8'd0));

    for (int i = 0; i < 1200; i++) begin
      idle_ok = !(i >= 400 && i < 700);
      if ($urandom_range(99) < 3) hot_base = nlst_pkg::NODE_W'($urandom);
      roll = $urandom_range(99);
      if (roll < 55) send(random_triangle());
      else if (roll < 93) send(make_other(nlst_pkg::REQ_READ, pick_node()));
      else if (roll < 96) send(make_other(nlst_pkg::REQ_CLEAR, nlst_pkg::NODE_W'($urandom)));
      else send(make_other(REQ_UNUSED, nlst_pkg::NODE_W'($urandom)));
    end
    start <= 1'b0;

    for (int w = 0; w < 500 && board.owed_scales.size() != 0; w++) @(posedge clk);
    board.mismatches += board.owed_scales.size();
    repeat (10) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
